### hdl/ddcf_pkg.sv
// Shared constants, types and register codes of the duty-to-CAN-frame block.
package ddcf_pkg;

   localparam int SPEED_W = 32;
   localparam int TRACK_W = 20;
   localparam int SCALE_W = 32;
   localparam int ID_W = 11;
   localparam int DLC_W = 4;
   localparam int DUTY_W = 11;
   localparam int BYTE_W = 8;
   localparam int FRAME_BYTES = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_MOTORS_READY = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_TRACK = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DUTY_SCALE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LEFT_ID = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RIGHT_ID = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_LEN = 3'd5;

   localparam logic [TRACK_W-1:0] HALF_TRACK_RESET = 20'd26214;
   localparam logic [SCALE_W-1:0] DUTY_SCALE_RESET = 32'd65536000;
   localparam logic [ID_W-1:0] LEFT_ID_RESET = 11'd1537;
   localparam logic [ID_W-1:0] RIGHT_ID_RESET = 11'd1538;
   localparam logic [DLC_W-1:0] FRAME_LEN_RESET = 4'd8;

   localparam logic [BYTE_W-1:0] SDO_COMMAND = 8'h2B;
   localparam logic [BYTE_W-1:0] OBJECT_LOW = 8'h01;
   localparam logic [BYTE_W-1:0] OBJECT_HIGH = 8'h20;
   localparam logic [BYTE_W-1:0] SUB_INDEX = 8'h00;
   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

   localparam logic [9:0] DUTY_LIMIT = 10'd1000;
   localparam logic [DLC_W-1:0] DLC_MAX = 4'd8;

   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = 1;
   localparam int CMD_CNT_W = 2;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   typedef struct packed {
      logic zero;
      logic signed [SPEED_W-1:0] linear;
      logic signed [SPEED_W-1:0] angular;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic [DUTY_W-1:0] left_duty;
      logic [DUTY_W-1:0] right_duty;
   } pair_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic last;
   } frame_type;

endpackage

### hdl/diff_drive_duty_to_can_frames.sv
// Top level: velocity command in, left and right CANopen duty frames out.
// A moving command runs the turn product and two partial products per wheel on the shared 33x33
// multiplier; a stop command goes straight to the frame pair. The datapath finishes one command
// before it takes the next.
// Up to two commands and two frame pairs wait in queues on either side of the datapath.
// Reset is synchronous: it empties both queues, zeroes stored duties, loads register defaults.
module diff_drive_duty_to_can_frames (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic signed [ddcf_pkg::SPEED_W-1:0] req_linear_speed,
   input  logic signed [ddcf_pkg::SPEED_W-1:0] req_angular_speed,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [ddcf_pkg::ID_W-1:0] rsp_can_id,
   output logic [ddcf_pkg::DLC_W-1:0] rsp_dlc,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_0,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_1,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_2,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_3,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_4,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_5,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_6,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_7,
   output logic rsp_last_of_run,
   input  logic csr_we,
   input  logic [ddcf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ddcf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ddcf_pkg::*;

   logic motors_ready_ff;
   logic [TRACK_W-1:0] half_track_ff;
   logic [SCALE_W-1:0] duty_scale_ff;
   logic [ID_W-1:0] left_id_ff, right_id_ff;
   logic [DLC_W-1:0] frame_len_ff;

   logic cmd_valid;
   cmd_type cmd_head;
   logic cmd_pop;
   logic out_room2;
   pair_type pair_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         motors_ready_ff <= 1'b0;
         half_track_ff <= HALF_TRACK_RESET;
         duty_scale_ff <= DUTY_SCALE_RESET;
         left_id_ff <= LEFT_ID_RESET;
         right_id_ff <= RIGHT_ID_RESET;
         frame_len_ff <= FRAME_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MOTORS_READY: motors_ready_ff <= csr_wdata[0];
            REG_HALF_TRACK: half_track_ff <= csr_wdata[TRACK_W-1:0];
            REG_DUTY_SCALE: duty_scale_ff <= csr_wdata[SCALE_W-1:0];
            REG_LEFT_ID: left_id_ff <= csr_wdata[ID_W-1:0];
            REG_RIGHT_ID: right_id_ff <= csr_wdata[ID_W-1:0];
            REG_FRAME_LEN: frame_len_ff <= csr_wdata[DLC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ddcf_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_linear_speed(req_linear_speed),
      .req_angular_speed(req_angular_speed),
      .motors_ready(motors_ready_ff),
      .cmd_valid(cmd_valid),
      .cmd_head(cmd_head),
      .cmd_pop(cmd_pop)
   );

   ddcf_back u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(cmd_valid),
      .cmd_head(cmd_head),
      .cmd_pop(cmd_pop),
      .half_track_width(half_track_ff),
      .duty_scale(duty_scale_ff),
      .out_room2(out_room2),
      .pair_push(pair_push)
   );

   ddcf_out u_out (
      .clock(clock),
      .reset(reset),
      .pair_push(pair_push),
      .out_room2(out_room2),
      .left_node_id(left_id_ff),
      .right_node_id(right_id_ff),
      .frame_length(frame_len_ff),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_can_id(rsp_can_id),
      .rsp_dlc(rsp_dlc),
      .rsp_data_0(rsp_data_0),
      .rsp_data_1(rsp_data_1),
      .rsp_data_2(rsp_data_2),
      .rsp_data_3(rsp_data_3),
      .rsp_data_4(rsp_data_4),
      .rsp_data_5(rsp_data_5),
      .rsp_data_6(rsp_data_6),
      .rsp_data_7(rsp_data_7),
      .rsp_last_of_run(rsp_last_of_run)
   );

`ifndef SYNTHESIS
   // A left frame is always followed by its right frame.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && !rsp_last_of_run |=> !rsp_empty && rsp_last_of_run)
      else $error("right frame missing after left frame beat");

   // After a right frame, the next waiting frame opens a new pair.
   a_pair_starts: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && rsp_last_of_run |=> rsp_empty || !rsp_last_of_run)
      else $error("frame pair does not start with a left frame beat");

   // The datapath only hands over a pair when the result queue has room for both frames.
   a_room: assert property (@(posedge clock) disable iff (reset)
      pair_push.valid |=> !rsp_empty)
      else $error("frame pair lost on push");
`endif

endmodule

### hdl/ddcf_front.sv
// Front end: accepts velocity commands, drops them while the drives are not ready, queues them.
module ddcf_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic signed [ddcf_pkg::SPEED_W-1:0] req_linear_speed,
   input  logic signed [ddcf_pkg::SPEED_W-1:0] req_angular_speed,
   input  logic motors_ready,
   output logic cmd_valid,
   output ddcf_pkg::cmd_type cmd_head,
   input  logic cmd_pop
);
   import ddcf_pkg::*;

   cmd_type entry_ff [CMD_DEPTH];
   cmd_type entry_in [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic store;
   logic take;

   assign req_full = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_head = entry_ff[rptr_ff];
   assign store = req_push && !req_full && motors_ready;
   assign take = cmd_pop && cmd_valid;

   always_comb begin
      entry_in = entry_ff;
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (store) begin
         entry_in[wptr_ff].zero = (req_linear_speed == '0) && (req_angular_speed == '0);
         entry_in[wptr_ff].linear = req_linear_speed;
         entry_in[wptr_ff].angular = req_angular_speed;
         wptr_in = wptr_ff + 1'b1;
      end
      if (take) begin
         rptr_in = rptr_ff + 1'b1;
      end
      if (store && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !store) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### hdl/ddcf_back.sv
// Back end: wheel speeds, duty scaling on one shared multiplier, change detection.
module ddcf_back (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   input  ddcf_pkg::cmd_type cmd_head,
   output logic cmd_pop,
   input  logic [ddcf_pkg::TRACK_W-1:0] half_track_width,
   input  logic [ddcf_pkg::SCALE_W-1:0] duty_scale,
   input  logic out_room2,
   output ddcf_pkg::pair_type pair_push
);
   import ddcf_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TURN = 3'd1;
   localparam logic [2:0] ST_SPEED = 3'd2;
   localparam logic [2:0] ST_ABS = 3'd3;
   localparam logic [2:0] ST_MHI = 3'd4;
   localparam logic [2:0] ST_MLO = 3'd5;
   localparam logic [2:0] ST_QUO = 3'd6;
   localparam logic [2:0] ST_EMIT = 3'd7;

   logic [2:0] state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [63:0] prod_ff, prod_in;
   logic [52:0] hi_ff, hi_in;
   logic signed [52:0] spd_l_ff, spd_l_in, spd_r_ff, spd_r_in;
   logic [52:0] mag_l_ff, mag_l_in, mag_r_ff, mag_r_in;
   logic neg_l_ff, neg_l_in, neg_r_ff, neg_r_in;
   logic side_ff, side_in;
   logic [DUTY_W-1:0] duty_l_ff, duty_l_in, duty_r_ff, duty_r_in;
   logic [DUTY_W-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic signed [52:0] base_x, turn_x;
   logic [52:0] mag_sel;
   logic neg_sel;
   logic [53:0] sum;
   logic [37:0] quo;
   logic [9:0] sat;
   logic [DUTY_W-1:0] duty;
   logic unchanged;

   assign mag_sel = side_ff ? mag_r_ff : mag_l_ff;
   assign neg_sel = side_ff ? neg_r_ff : neg_l_ff;

   always_comb begin
      unique case (state_ff)
         ST_TURN: begin
            mul_a = {cmd_ff.angular[SPEED_W-1], cmd_ff.angular};
            mul_b = {13'd0, half_track_width};
         end
         ST_MHI: begin
            mul_a = {12'd0, mag_sel[52:32]};
            mul_b = {1'b0, duty_scale};
         end
         default: begin
            mul_a = {1'b0, mag_sel[31:0]};
            mul_b = {1'b0, duty_scale};
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign base_x = {{5{cmd_ff.linear[SPEED_W-1]}}, cmd_ff.linear, 16'd0};
   assign turn_x = {prod_ff[51], prod_ff[51:0]};
   assign sum = {1'b0, hi_ff} + {22'd0, prod_ff[63:32]};
   assign quo = sum[53:16];
   assign sat = (quo > 38'(DUTY_LIMIT)) ? DUTY_LIMIT : quo[9:0];
   assign duty = neg_sel ? (DUTY_W'(0) - {1'b0, sat}) : {1'b0, sat};
   assign unchanged = !cmd_ff.zero && (duty_l_ff == prev_l_ff) && (duty_r_ff == prev_r_ff);

   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;
   assign pair_push.valid = (state_ff == ST_EMIT) && !unchanged && out_room2;
   assign pair_push.left_duty = duty_l_ff;
   assign pair_push.right_duty = duty_r_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      prod_in = prod_ff;
      hi_in = hi_ff;
      spd_l_in = spd_l_ff;
      spd_r_in = spd_r_ff;
      mag_l_in = mag_l_ff;
      mag_r_in = mag_r_ff;
      neg_l_in = neg_l_ff;
      neg_r_in = neg_r_ff;
      side_in = side_ff;
      duty_l_in = duty_l_ff;
      duty_r_in = duty_r_ff;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_head;
               if (cmd_head.zero) begin
                  duty_l_in = '0;
                  duty_r_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_TURN;
               end
            end
         end
         ST_TURN: begin
            prod_in = mul_p[63:0];
            state_in = ST_SPEED;
         end
         ST_SPEED: begin
            spd_l_in = base_x - turn_x;
            spd_r_in = base_x + turn_x;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_l_in = spd_l_ff[52];
            neg_r_in = spd_r_ff[52];
            mag_l_in = spd_l_ff[52] ? (53'd0 - spd_l_ff) : spd_l_ff;
            mag_r_in = spd_r_ff[52] ? (53'd0 - spd_r_ff) : spd_r_ff;
            side_in = 1'b0;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            prod_in = mul_p[63:0];
            state_in = ST_MLO;
         end
         ST_MLO: begin
            hi_in = prod_ff[52:0];
            prod_in = mul_p[63:0];
            state_in = ST_QUO;
         end
         ST_QUO: begin
            if (side_ff) begin
               duty_r_in = duty;
               state_in = ST_EMIT;
            end else begin
               duty_l_in = duty;
               side_in = 1'b1;
               state_in = ST_MHI;
            end
         end
         ST_EMIT: begin
            if (unchanged) begin
               state_in = ST_IDLE;
            end else if (out_room2) begin
               if (!cmd_ff.zero) begin
                  prev_l_in = duty_l_ff;
                  prev_r_in = duty_r_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      prod_ff <= prod_in;
      hi_ff <= hi_in;
      spd_l_ff <= spd_l_in;
      spd_r_ff <= spd_r_in;
      mag_l_ff <= mag_l_in;
      mag_r_ff <= mag_r_in;
      neg_l_ff <= neg_l_in;
      neg_r_ff <= neg_r_in;
      side_ff <= side_in;
      duty_l_ff <= duty_l_in;
      duty_r_ff <= duty_r_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
      end else begin
         state_ff <= state_in;
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
      end
   end

endmodule

### hdl/ddcf_out.sv
// Result queue of frame pairs and formatting of the SDO-write frame bytes.
module ddcf_out (
   input  logic clock,
   input  logic reset,
   input  ddcf_pkg::pair_type pair_push,
   output logic out_room2,
   input  logic [ddcf_pkg::ID_W-1:0] left_node_id,
   input  logic [ddcf_pkg::ID_W-1:0] right_node_id,
   input  logic [ddcf_pkg::DLC_W-1:0] frame_length,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [ddcf_pkg::ID_W-1:0] rsp_can_id,
   output logic [ddcf_pkg::DLC_W-1:0] rsp_dlc,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_0,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_1,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_2,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_3,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_4,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_5,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_6,
   output logic [ddcf_pkg::BYTE_W-1:0] rsp_data_7,
   output logic rsp_last_of_run
);
   import ddcf_pkg::*;

   frame_type entry_ff [OUT_DEPTH];
   frame_type entry_in [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [OUT_CNT_W-1:0] count_ff, count_in;
   logic take;
   frame_type head;
   logic [DLC_W-1:0] dlc;
   logic [15:0] duty16;
   logic [BYTE_W-1:0] raw [FRAME_BYTES];
   logic [BYTE_W-1:0] data [FRAME_BYTES];

   assign rsp_empty = (count_ff == '0);
   assign out_room2 = (count_ff <= OUT_CNT_W'(OUT_DEPTH - 2));
   assign take = rsp_pop && !rsp_empty;

   always_comb begin
      entry_in = entry_ff;
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (pair_push.valid) begin
         entry_in[wptr_ff].duty = pair_push.left_duty;
         entry_in[wptr_ff].last = 1'b0;
         entry_in[OUT_PTR_W'(wptr_ff + 1'b1)].duty = pair_push.right_duty;
         entry_in[OUT_PTR_W'(wptr_ff + 1'b1)].last = 1'b1;
         wptr_in = wptr_ff + OUT_PTR_W'(2);
      end
      if (take) begin
         rptr_in = rptr_ff + 1'b1;
      end
      if (pair_push.valid && take) begin
         count_in = count_ff + 1'b1;
      end else if (pair_push.valid) begin
         count_in = count_ff + OUT_CNT_W'(2);
      end else if (take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   assign head = entry_ff[rptr_ff];
   assign dlc = (frame_length > DLC_MAX) ? DLC_MAX : frame_length;
   assign duty16 = {{(16 - DUTY_W){head.duty[DUTY_W-1]}}, head.duty};

   always_comb begin
      raw[0] = SDO_COMMAND;
      raw[1] = OBJECT_LOW;
      raw[2] = OBJECT_HIGH;
      raw[3] = SUB_INDEX;
      raw[4] = duty16[7:0];
      raw[5] = duty16[15:8];
      raw[6] = PAD_BYTE;
      raw[7] = PAD_BYTE;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         data[i] = (DLC_W'(i) < dlc) ? raw[i] : '0;
      end
   end

   assign rsp_can_id = head.last ? right_node_id : left_node_id;
   assign rsp_dlc = dlc;
   assign rsp_data_0 = data[0];
   assign rsp_data_1 = data[1];
   assign rsp_data_2 = data[2];
   assign rsp_data_3 = data[3];
   assign rsp_data_4 = data[4];
   assign rsp_data_5 = data[5];
   assign rsp_data_6 = data[6];
   assign rsp_data_7 = data[7];
   assign rsp_last_of_run = head.last;

endmodule

### sim/tb.sv
// Testbench for diff_drive_duty_to_can_frames: directed and random commands checked beat by beat.
`timescale 1ns / 100ps

module tb;
   import ddcf_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0] can_id;
      logic [DLC_W-1:0] dlc;
      logic [FRAME_BYTES-1:0][BYTE_W-1:0] data;
      logic last;
   } can_frame_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam logic signed [SPEED_W-1:0] ONE_Q16 = 32'sh0001_0000;
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = 32'sh8000_0000;
   localparam int QUIET_CYCLES = 60;
   localparam int MAX_GAP = 40;
   localparam int SEGMENTS = 12;
   localparam int SEGMENT_ITEMS = 100;

   logic clock = 1'b0;
   logic reset;
   logic req_push;
   logic req_full;
   logic signed [SPEED_W-1:0] req_linear_speed;
   logic signed [SPEED_W-1:0] req_angular_speed;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [ID_W-1:0] rsp_can_id;
   logic [DLC_W-1:0] rsp_dlc;
   logic [BYTE_W-1:0] rsp_data_0, rsp_data_1, rsp_data_2, rsp_data_3;
   logic [BYTE_W-1:0] rsp_data_4, rsp_data_5, rsp_data_6, rsp_data_7;
   logic rsp_last_of_run;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Register copies and stored duties of the duty predictor.
   logic ready_q;
   logic [TRACK_W-1:0] track_q;
   logic [SCALE_W-1:0] scale_q;
   logic [ID_W-1:0] left_id_q;
   logic [ID_W-1:0] right_id_q;
   logic [DLC_W-1:0] frame_len_q;
   logic [DUTY_W-1:0] stored_left_duty;
   logic [DUTY_W-1:0] stored_right_duty;

   can_frame_type pending_frames[$];
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int commands_sent = 0;
   int frames_checked = 0;
   int reg_writes = 0;
   int mismatches = 0;

   diff_drive_duty_to_can_frames dut (.*);

   always #10 clock = ~clock;

   initial begin
      #(64'd20_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         note_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
      end
   endtask

   function automatic logic [DUTY_W-1:0] wheel_duty(input logic signed [63:0] speed);
      logic [63:0] mag;
      logic [127:0] product;
      logic [DUTY_W-1:0] duty;
      mag = speed[63] ? 64'(-speed) : 64'(speed);
      product = {64'd0, mag} * {96'd0, scale_q};
      // The integer part of a Q.48 product, truncated toward zero, then saturated.
      if (product[127:48] > DUTY_LIMIT) begin
         duty = DUTY_W'(DUTY_LIMIT);
      end else begin
         duty = product[58:48];
      end
      return speed[63] ? -duty : duty;
   endfunction

   function automatic can_frame_type build_frame(input logic [ID_W-1:0] id,
                                                 input logic [DUTY_W-1:0] duty,
                                                 input logic last);
      can_frame_type f;
      logic [15:0] duty16;
      logic [DLC_W-1:0] len;
      logic [BYTE_W-1:0] bytes [FRAME_BYTES];
      len = (frame_len_q > DLC_MAX) ? DLC_MAX : frame_len_q;
      duty16 = {{5{duty[DUTY_W-1]}}, duty};
      bytes = '{SDO_COMMAND, OBJECT_LOW, OBJECT_HIGH, SUB_INDEX,
                duty16[7:0], duty16[15:8], PAD_BYTE, PAD_BYTE};
      f.can_id = id;
      f.dlc = len;
      f.last = last;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         f.data[i] = (i < len) ? bytes[i] : '0;
      end
      return f;
   endfunction

   task automatic predict_frames(input logic signed [SPEED_W-1:0] lin,
                                 input logic signed [SPEED_W-1:0] ang);
      logic signed [63:0] base;
      logic signed [63:0] ang64;
      logic signed [63:0] track64;
      logic signed [63:0] turn;
      logic [DUTY_W-1:0] left_duty;
      logic [DUTY_W-1:0] right_duty;
      if (!ready_q) return;
      if (lin == 0 && ang == 0) begin
         pending_frames.push_back(build_frame(left_id_q, '0, 1'b0));
         pending_frames.push_back(build_frame(right_id_q, '0, 1'b1));
         return;
      end
      base = {{16{lin[SPEED_W-1]}}, lin, 16'd0};
      ang64 = ang;
      track64 = {44'd0, track_q};
      turn = ang64 * track64;
      left_duty = wheel_duty(base - turn);
      right_duty = wheel_duty(base + turn);
      if (left_duty == stored_left_duty && right_duty == stored_right_duty) return;
      pending_frames.push_back(build_frame(left_id_q, left_duty, 1'b0));
      pending_frames.push_back(build_frame(right_id_q, right_duty, 1'b1));
      stored_left_duty = left_duty;
      stored_right_duty = right_duty;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         REG_MOTORS_READY: ready_q = value[0];
         REG_HALF_TRACK: track_q = value[TRACK_W-1:0];
         REG_DUTY_SCALE: scale_q = value[SCALE_W-1:0];
         REG_LEFT_ID: left_id_q = value[ID_W-1:0];
         REG_RIGHT_ID: right_id_q = value[ID_W-1:0];
         REG_FRAME_LEN: frame_len_q = value[DLC_W-1:0];
         default: ;
      endcase
      reg_writes++;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_command(input logic signed [SPEED_W-1:0] lin,
                               input logic signed [SPEED_W-1:0] ang);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_linear_speed <= lin;
      req_angular_speed <= ang;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_frames(lin, ang);
      commands_sent++;
   endtask

   task automatic wait_for_quiet();
      req_push <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            pop_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 63;
            pop_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            pop_stall_pct = 63;
         end
         default: begin
            send_idle_pct = 8;
            pop_stall_pct = 8;
         end
      endcase
   endtask

   function automatic logic signed [SPEED_W-1:0] rand_speed();
      logic signed [SPEED_W-1:0] raw;
      raw = $urandom;
      case ($urandom_range(9))
         0: return '0;
         1: return $urandom_range(1) ? SPEED_MAX : SPEED_MIN;
         2: return raw;
         default: return raw >>> $urandom_range(30, 8);
      endcase
   endfunction

   // Each beat on the result side is compared with the oldest predicted frame.
   always @(posedge clock) begin : frame_checker
      can_frame_type got;
      can_frame_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.can_id = rsp_can_id;
         got.dlc = rsp_dlc;
         got.data = {rsp_data_7, rsp_data_6, rsp_data_5, rsp_data_4,
                     rsp_data_3, rsp_data_2, rsp_data_1, rsp_data_0};
         got.last = rsp_last_of_run;
         if (pending_frames.size() == 0) begin
            note_mismatch($sformatf("unexpected frame, id %0h", got.can_id));
         end else begin
            want = pending_frames.pop_front();
            check_field("can_id", 16'(want.can_id), 16'(got.can_id));
            check_field("dlc", 16'(want.dlc), 16'(got.dlc));
            for (int i = 0; i < FRAME_BYTES; i++) begin
               check_field($sformatf("data_%0d", i), 16'(want.data[i]), 16'(got.data[i]));
            end
            check_field("last_of_run", 16'(want.last), 16'(got.last));
            frames_checked++;
         end
      end
      rsp_pop <= !reset && ($urandom_range(99) >= pop_stall_pct);
   end

   task automatic test_not_ready();
      send_command('0, '0);
      send_command(ONE_Q16, '0);
      send_command(SPEED_MIN, SPEED_MAX);
      wait_for_quiet();
   endtask

   task automatic test_wheel_duties();
      write_reg(REG_MOTORS_READY, 32'd1);
      send_command('0, '0);
      send_command(ONE_Q16, '0);
      send_command(ONE_Q16 / 2, '0);
      send_command(ONE_Q16 / 2, '0);
      send_command('0, ONE_Q16);
      send_command('0, '0);
      send_command('0, ONE_Q16);
      send_command(-32'sd1, '0);
      send_command(SPEED_MAX, '0);
      send_command(SPEED_MIN, '0);
      send_command('0, SPEED_MAX);
      send_command('0, SPEED_MIN);
      send_command(SPEED_MIN, SPEED_MIN);
      wait_for_quiet();
   endtask

   task automatic test_frame_layout();
      logic [DLC_W-1:0] lengths [3];
      lengths = '{4'd0, 4'd5, 4'd15};
      write_reg(REG_LEFT_ID, 32'd0);
      write_reg(REG_RIGHT_ID, 32'd2047);
      for (int k = 0; k < 3; k++) begin
         write_reg(REG_FRAME_LEN, {28'd0, lengths[k]});
         send_command('0, '0);
         send_command(k[0] ? ONE_Q16 / 2 : -ONE_Q16 / 2, ONE_Q16 / 4);
         wait_for_quiet();
      end
   endtask

   task automatic test_scaling_extremes();
      write_reg(REG_HALF_TRACK, 32'hF_FFFF);
      send_command(ONE_Q16 / 8, ONE_Q16 / 1000);
      wait_for_quiet();
      write_reg(REG_HALF_TRACK, 32'd0);
      send_command(-ONE_Q16 / 8, SPEED_MAX);
      wait_for_quiet();
      write_reg(REG_DUTY_SCALE, 32'd0);
      send_command(SPEED_MAX, SPEED_MIN);
      wait_for_quiet();
      write_reg(REG_DUTY_SCALE, 32'hFFFF_FFFF);
      send_command(32'sd3, -32'sd2);
      wait_for_quiet();
   endtask

   task automatic randomize_config();
      logic [CSR_DATA_W-1:0] value;
      value = $urandom;
      value[0] = ($urandom_range(9) != 0);
      write_reg(REG_MOTORS_READY, value);
      value = $urandom;
      case ($urandom_range(5))
         0: value[TRACK_W-1:0] = '0;
         1: value[TRACK_W-1:0] = '1;
         2: value[TRACK_W-1:0] = HALF_TRACK_RESET;
         default: value[TRACK_W-1:0] = value[TRACK_W-1:0] >> $urandom_range(19);
      endcase
      write_reg(REG_HALF_TRACK, value);
      value = $urandom;
      case ($urandom_range(5))
         0: value = '0;
         1: value = '1;
         2: value = DUTY_SCALE_RESET;
         default: value = value >> $urandom_range(31);
      endcase
      write_reg(REG_DUTY_SCALE, value);
      value = $urandom;
      if ($urandom_range(3) == 0) value[ID_W-1:0] = '1;
      write_reg(REG_LEFT_ID, value);
      value = $urandom;
      if ($urandom_range(3) == 0) value[ID_W-1:0] = '0;
      write_reg(REG_RIGHT_ID, value);
      value = $urandom;
      if ($urandom_range(1) == 0) value[DLC_W-1:0] = FRAME_LEN_RESET;
      write_reg(REG_FRAME_LEN, value);
   endtask

   task automatic test_random_commands();
      logic signed [SPEED_W-1:0] lin;
      logic signed [SPEED_W-1:0] ang;
      lin = '0;
      ang = '0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_for_quiet();
         randomize_config();
         set_idling(idle_mode_type'(seg % 4));
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            case ($urandom_range(19))
               0, 1: begin
                  lin = '0;
                  ang = '0;
               end
               2, 3, 4: ;
               5: lin = lin + $signed(32'($urandom_range(64))) - 32'sd32;
               default: begin
                  lin = rand_speed();
                  ang = rand_speed();
               end
            endcase
            send_command(lin, ang);
         end
      end
      wait_for_quiet();
   endtask

   initial begin
      reset <= 1'b1;
      req_push <= 1'b0;
      req_linear_speed <= '0;
      req_angular_speed <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_MOTORS_READY;
      csr_wdata <= '0;
      ready_q = 1'b0;
      track_q = HALF_TRACK_RESET;
      scale_q = DUTY_SCALE_RESET;
      left_id_q = LEFT_ID_RESET;
      right_id_q = RIGHT_ID_RESET;
      frame_len_q = FRAME_LEN_RESET;
      stored_left_duty = '0;
      stored_right_duty = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(IDLE_NONE);
      test_not_ready();
      test_wheel_duties();
      test_frame_layout();
      test_scaling_extremes();
      test_random_commands();

      if (pending_frames.size() != 0) begin
         note_mismatch($sformatf("%0d predicted frames never arrived", pending_frames.size()));
      end
      $display("Sent %0d velocity commands across %0d register writes and four idling patterns.",
               commands_sent, reg_writes);
      $display("Checked %0d CAN frames, %0d mismatches found.", frames_checked, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
hdl/ddcf_pkg.sv
hdl/ddcf_front.sv
hdl/ddcf_back.sv
hdl/ddcf_out.sv
hdl/diff_drive_duty_to_can_frames.sv
sim/tb.sv
